// ===== rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    // Geometry of the staff and of the data path
    localparam int MAX_LINES     = 5;
    localparam int LEDGER_LEVELS = 3;
    localparam int ROW_BITS      = 12;

    localparam int ROW_REGS  = 5;
    localparam int NOTE_W    = 16;
    localparam int STEP_W    = 5;
    localparam int LCNT_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = ROW_BITS;

    // Candidate coordinates reach 16*row plus 48 spacings, signed
    localparam int CAND_W = (ROW_BITS + 8 > 18) ? ROW_BITS + 8 : 18;

    // Extra slot keeps the top spacing defined for a single line
    localparam int SORT_N = (MAX_LINES < 2) ? 2 : MAX_LINES;

    // Lines, midpoints, then four entries per ledger level
    localparam int NCAND    = 2 * MAX_LINES - 1 + 4 * LEDGER_LEVELS;
    localparam int MID_BASE = MAX_LINES;
    localparam int LED_BASE = 2 * MAX_LINES - 1;

    // Two leading cells only delay the note while new settings settle
    localparam int DLY_CELLS = 2;
    localparam int NCELL     = NCAND + DLY_CELLS;

    // Top line position; each further line steps down by two
    localparam int TOP_POS = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_A      = 3'd0,
        REG_ROW_B      = 3'd1,
        REG_ROW_C      = 3'd2,
        REG_ROW_D      = 3'd3,
        REG_ROW_E      = 3'd4,
        REG_LINE_COUNT = 3'd5
    } cfg_reg_t;

    // One candidate position and where it sits, in 1/16 pixel
    typedef struct packed {
        logic                     en;
        logic signed [CAND_W-1:0] value;
        logic signed [STEP_W-1:0] pos;
    } cand_t;

    // Word travelling down the chain with the best match so far
    typedef struct packed {
        logic                     valid;
        logic [NOTE_W-1:0]        note;
        logic [CAND_W-1:0]        best_dist;
        logic signed [STEP_W-1:0] best_pos;
        logic                     have;
    } cell_t;

endpackage

`default_nettype wire

// ===== rtl/spq_table.sv =====
`default_nettype none

module spq_table (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [spq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [spq_pkg::CFG_W-1:0]     cfg_data,
    output spq_pkg::cand_t                    cand_o [spq_pkg::NCAND]
);

    logic [spq_pkg::ROW_BITS-1:0] row_reg [spq_pkg::ROW_REGS];
    logic [spq_pkg::LCNT_W-1:0]   lcnt_reg;

    logic [spq_pkg::LCNT_W-1:0]   n_next;
    logic [spq_pkg::LCNT_W-1:0]   n_reg;
    logic [spq_pkg::LCNT_W-1:0]   rank [spq_pkg::MAX_LINES];
    logic [spq_pkg::ROW_BITS-1:0] sorted_next [spq_pkg::SORT_N];
    logic [spq_pkg::ROW_BITS-1:0] sorted_reg  [spq_pkg::SORT_N];

    logic signed [spq_pkg::CAND_W-1:0] yw [spq_pkg::SORT_N];
    logic signed [spq_pkg::CAND_W-1:0] top_sp;
    logic signed [spq_pkg::CAND_W-1:0] bot_sp;
    logic signed [spq_pkg::CAND_W-1:0] t0;
    logic signed [spq_pkg::CAND_W-1:0] b0;
    spq_pkg::cand_t                    cand_next [spq_pkg::NCAND];
    spq_pkg::cand_t                    cand_reg  [spq_pkg::NCAND];

    assign cfg_ready = 1'b1;

    // Take register writes; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < spq_pkg::ROW_REGS; i++) begin
                row_reg[i] <= '0;
            end
            lcnt_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                spq_pkg::REG_ROW_A: row_reg[0] <= cfg_data[spq_pkg::ROW_BITS-1:0];
                spq_pkg::REG_ROW_B: row_reg[1] <= cfg_data[spq_pkg::ROW_BITS-1:0];
                spq_pkg::REG_ROW_C: row_reg[2] <= cfg_data[spq_pkg::ROW_BITS-1:0];
                spq_pkg::REG_ROW_D: row_reg[3] <= cfg_data[spq_pkg::ROW_BITS-1:0];
                spq_pkg::REG_ROW_E: row_reg[4] <= cfg_data[spq_pkg::ROW_BITS-1:0];
                spq_pkg::REG_LINE_COUNT: lcnt_reg <= cfg_data[spq_pkg::LCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate the count and rank each valid row; equal rows keep index order
    always_comb begin
        n_next = (lcnt_reg > spq_pkg::LCNT_W'(spq_pkg::MAX_LINES))
               ? spq_pkg::LCNT_W'(spq_pkg::MAX_LINES) : lcnt_reg;
        for (int i = 0; i < spq_pkg::MAX_LINES; i++) begin
            rank[i] = '0;
            for (int j = 0; j < spq_pkg::MAX_LINES; j++) begin
                if ((j != i) && (spq_pkg::LCNT_W'(j) < n_next) &&
                    ((row_reg[j] < row_reg[i]) ||
                     ((row_reg[j] == row_reg[i]) && (j < i)))) begin
                    rank[i] = rank[i] + 1'b1;
                end
            end
        end
        for (int r = 0; r < spq_pkg::SORT_N; r++) begin
            sorted_next[r] = '0;
            for (int i = 0; i < spq_pkg::MAX_LINES; i++) begin
                if ((spq_pkg::LCNT_W'(i) < n_next) &&
                    (rank[i] == spq_pkg::LCNT_W'(r))) begin
                    sorted_next[r] = row_reg[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= '0;
            for (int r = 0; r < spq_pkg::SORT_N; r++) begin
                sorted_reg[r] <= '0;
            end
        end else begin
            n_reg <= n_next;
            for (int r = 0; r < spq_pkg::SORT_N; r++) begin
                sorted_reg[r] <= sorted_next[r];
            end
        end
    end

    // Spacings and end lines for the ledger levels
    always_comb begin
        for (int k = 0; k < spq_pkg::SORT_N; k++) begin
            yw[k] = $signed({{(spq_pkg::CAND_W - spq_pkg::ROW_BITS){1'b0}}, sorted_reg[k]});
        end
        top_sp = yw[1] - yw[0];
        t0     = yw[0] <<< 4;
        bot_sp = top_sp;
        b0     = yw[1] <<< 4;
        for (int k = 1; k < spq_pkg::MAX_LINES; k++) begin
            if (n_reg == spq_pkg::LCNT_W'(k + 1)) begin
                bot_sp = yw[k] - yw[k-1];
                b0     = yw[k] <<< 4;
            end
        end
    end

    // Lay out every candidate in scan order
    always_comb begin
        for (int i = 0; i < spq_pkg::MAX_LINES; i++) begin
            cand_next[i].en    = spq_pkg::LCNT_W'(i) < n_reg;
            cand_next[i].value = yw[i] <<< 4;
            cand_next[i].pos   = spq_pkg::STEP_W'(spq_pkg::TOP_POS - 2 * i);
        end
        for (int i = 0; i + 1 < spq_pkg::MAX_LINES; i++) begin
            cand_next[spq_pkg::MID_BASE + i].en    = spq_pkg::LCNT_W'(i + 1) < n_reg;
            cand_next[spq_pkg::MID_BASE + i].value = (yw[i] + yw[i+1]) <<< 3;
            cand_next[spq_pkg::MID_BASE + i].pos   =
                spq_pkg::STEP_W'(spq_pkg::TOP_POS - 1 - 2 * i);
        end
        for (int d = 1; d <= spq_pkg::LEDGER_LEVELS; d++) begin
            for (int e = 0; e < 4; e++) begin
                cand_next[spq_pkg::LED_BASE + 4 * (d - 1) + e].en =
                    n_reg >= spq_pkg::LCNT_W'(2);
            end
            cand_next[spq_pkg::LED_BASE + 4 * (d - 1)].value =
                t0 - top_sp * $signed(spq_pkg::CAND_W'(16 * d));
            cand_next[spq_pkg::LED_BASE + 4 * (d - 1)].pos =
                spq_pkg::STEP_W'(spq_pkg::TOP_POS + 2 * d);
            cand_next[spq_pkg::LED_BASE + 4 * (d - 1) + 1].value =
                b0 + bot_sp * $signed(spq_pkg::CAND_W'(16 * d));
            cand_next[spq_pkg::LED_BASE + 4 * (d - 1) + 1].pos =
                spq_pkg::STEP_W'(-spq_pkg::TOP_POS - 2 * d);
            cand_next[spq_pkg::LED_BASE + 4 * (d - 1) + 2].value =
                t0 - top_sp * $signed(spq_pkg::CAND_W'(16 * d - 8));
            cand_next[spq_pkg::LED_BASE + 4 * (d - 1) + 2].pos =
                spq_pkg::STEP_W'(spq_pkg::TOP_POS - 1 + 2 * d);
            cand_next[spq_pkg::LED_BASE + 4 * (d - 1) + 3].value =
                b0 + bot_sp * $signed(spq_pkg::CAND_W'(16 * d - 8));
            cand_next[spq_pkg::LED_BASE + 4 * (d - 1) + 3].pos =
                spq_pkg::STEP_W'(1 - spq_pkg::TOP_POS - 2 * d);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < spq_pkg::NCAND; c++) begin
                cand_reg[c] <= '0;
            end
        end else begin
            for (int c = 0; c < spq_pkg::NCAND; c++) begin
                cand_reg[c] <= cand_next[c];
            end
        end
    end

    assign cand_o = cand_reg;

endmodule

`default_nettype wire

// ===== rtl/spq_cell.sv =====
`default_nettype none

module spq_cell (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   advance,
    input  wire spq_pkg::cell_t prev_i,
    input  wire spq_pkg::cand_t cand_i,
    output spq_pkg::cell_t stage_o
);

    spq_pkg::cell_t stage_reg;
    spq_pkg::cell_t stage_next;

    logic signed [spq_pkg::CAND_W:0] diff;
    logic [spq_pkg::CAND_W-1:0]      delta_abs;

    // Compare this cell's candidate against the best so far
    always_comb begin
        diff = $signed({cand_i.value[spq_pkg::CAND_W-1], cand_i.value})
             - $signed({{(spq_pkg::CAND_W + 1 - spq_pkg::NOTE_W){1'b0}}, prev_i.note});
        delta_abs = diff[spq_pkg::CAND_W] ? spq_pkg::CAND_W'(-diff)
                                          : diff[spq_pkg::CAND_W-1:0];
        stage_next = prev_i;
        if (cand_i.en && (!prev_i.have || (delta_abs < prev_i.best_dist))) begin
            stage_next.best_dist = delta_abs;
            stage_next.best_pos  = cand_i.pos;
            stage_next.have      = 1'b1;
        end
    end

    // Hold while the chain is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (advance) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_o = stage_reg;

endmodule

`default_nettype wire

// ===== rtl/staff_position_quantizer.sv =====
// Staff position quantizer.
// A note's vertical center (1/16 pixel) enters on the s_ stream; the nearest
// staff step (0 is the middle line, up is positive) leaves on the m_ stream.
// Staff line rows and the line count must be written on the cfg channel only
// while no note is in flight; the block does not enforce this. A write takes
// effect for notes accepted after it. Throughput: one note per cycle while the
// output buffer has room. Each candidate position is one cell of a chain,
// preceded by two delay cells, so a note passes 23 cells and then goes into
// the output buffer, whose count register raises m_tvalid.
// The output is a two-word buffer: input is taken while one result waits;
// only with both words held does s_tready drop and the chain hold in place.
// Reset clears the staff settings to zero and empties the chain and the
// buffer; the cfg channel is always ready.
`default_nettype none

module staff_position_quantizer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,   // [15:0] note_center
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,   // [4:0] staff_step
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [spq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [spq_pkg::CFG_W-1:0]     cfg_data
);

    spq_pkg::cand_t cand [spq_pkg::NCAND];
    spq_pkg::cand_t cell_cand [spq_pkg::NCELL];
    spq_pkg::cell_t chain [spq_pkg::NCELL];
    spq_pkg::cell_t head;

    logic        advance;
    logic        push;
    logic        pop;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic signed [spq_pkg::STEP_W-1:0] slot0_reg;
    logic signed [spq_pkg::STEP_W-1:0] slot1_reg;

    spq_table u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cand_o    (cand)
    );

    // Feed the chain; delay cells get no candidate
    always_comb begin
        head.valid     = s_tvalid;
        head.note      = s_tdata[spq_pkg::NOTE_W-1:0];
        head.best_dist = '0;
        head.best_pos  = '0;
        head.have      = 1'b0;
        for (int k = 0; k < spq_pkg::DLY_CELLS; k++) begin
            cell_cand[k] = '0;
        end
        for (int c = 0; c < spq_pkg::NCAND; c++) begin
            cell_cand[c + spq_pkg::DLY_CELLS] = cand[c];
        end
    end

    for (genvar k = 0; k < spq_pkg::NCELL; k++) begin : g_cell
        if (k == 0) begin : g_first
            spq_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .advance (advance),
                .prev_i  (head),
                .cand_i  (cell_cand[k]),
                .stage_o (chain[k])
            );
        end else begin : g_next
            spq_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .advance (advance),
                .prev_i  (chain[k-1]),
                .cand_i  (cell_cand[k]),
                .stage_o (chain[k])
            );
        end
    end

    // Advance the chain whenever the output buffer has room
    assign advance  = (count_reg != 2'd2);
    assign s_tready = advance;
    assign push     = advance && chain[spq_pkg::NCELL-1].valid;
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Two-word output buffer: slot 0 drives the port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && (count_reg == 2'd2)) begin
            slot0_reg <= slot1_reg;
        end
        if (push) begin
            if ((count_reg == 2'd0) || ((count_reg == 2'd1) && pop)) begin
                slot0_reg <= chain[spq_pkg::NCELL-1].best_pos;
            end else begin
                slot1_reg <= chain[spq_pkg::NCELL-1].best_pos;
            end
        end
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {{(8 - spq_pkg::STEP_W){1'b0}}, slot0_reg};

    // Buffer never claims a third word
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    // Every delivered step lies within the ledger range
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (($signed(m_tdata[spq_pkg::STEP_W-1:0]) <= 5'sd10) &&
                      ($signed(m_tdata[spq_pkg::STEP_W-1:0]) >= -5'sd10)))
        else $error("staff step out of range");

    // A full buffer with a stalled receiver keeps input blocked
    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        ((count_reg == 2'd2) && !m_tready) |=> !s_tready)
        else $error("input taken while output buffer full");

    // Reset empties the buffer
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

endmodule

`default_nettype wire
